### rtl/core/mecanum_chassis_follow_mixer_core_assert.svh
// assertion macros used by the chassis mixer top level
`ifndef MECANUM_CHASSIS_FOLLOW_MIXER_CORE_ASSERT_SVH
`define MECANUM_CHASSIS_FOLLOW_MIXER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define MCFM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("chassis mixer assertion failed");

// next-cycle implication
`define MCFM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("chassis mixer assertion failed");

`endif

### rtl/core/mcfm_pkg.sv
// shared constants, codes and the arctangent table of the chassis mixer
`timescale 1ns / 1ps
package mcfm_pkg;

  localparam int TRIG_FRAC_BITS_DEF = 15;
  localparam int CORDIC_STEPS_DEF   = 16;
  localparam int ATAN_COUNT         = 24;
  localparam int AIW                = 5;

  localparam int CFG_W = 16;
  localparam int IDX_W = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_FRONT_DEF = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRONT_ALT = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROT_REF   = 3'd2;
  localparam logic [IDX_W-1:0] REG_SPIN      = 3'd3;
  localparam logic [IDX_W-1:0] REG_DEADBAND  = 3'd4;
  localparam logic [IDX_W-1:0] REG_LIMIT     = 3'd5;

  // register reset values
  localparam logic [12:0]        FRONT_DEF_RST = 13'd1335;
  localparam logic [12:0]        FRONT_ALT_RST = 13'd2316;
  localparam logic [12:0]        ROT_REF_RST   = 13'd1335;
  localparam logic signed [15:0] SPIN_RST      = 16'sd5200;
  localparam logic [12:0]        DEADBAND_RST  = 13'd156;
  localparam logic [13:0]        LIMIT_RST     = 14'd3600;

  // control source and switch codes
  localparam logic [1:0] MODE_RC  = 2'd1;
  localparam logic [1:0] MODE_KEY = 2'd2;
  localparam logic [1:0] SW_OFF   = 2'd0;
  localparam logic [1:0] SW_SPIN  = 2'd2;

  // key choice codes
  localparam logic [1:0] KEY_FOLLOW = 2'd0;
  localparam logic [1:0] KEY_SPIN   = 2'd1;
  localparam logic [1:0] KEY_ALT    = 2'd2;

  // angle scaling: z = (ch * 628 * 2^28 + 409550) / 819100
  localparam logic [9:0]  ANG_SCALE = 10'd628;
  localparam logic [27:0] ANG_BIAS  = 28'd409550;
  localparam logic [20:0] ANG_DIV   = 21'd819100;
  localparam logic [12:0] ECD_SPAN  = 13'd8191;

  localparam logic signed [31:0] ANG_PI      = 32'sd843314857;
  localparam logic signed [31:0] ANG_TWO_PI  = 32'sd1686629714;
  localparam logic signed [31:0] ANG_HALF_PI = 32'sd421657428;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  typedef logic signed [31:0] atan_tab_t [ATAN_COUNT];

  // restoring long division, used to build constants
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // z = ch * ANG_QP + (ch * ANG_RP + bias) / div, the second part by reciprocal multiply
  localparam logic [63:0] ANG_NUM   = 64'(ANG_SCALE) << 28;
  localparam logic [63:0] ANG_QP64  = udiv64(ANG_NUM, 64'(ANG_DIV));
  localparam logic [17:0] ANG_QP    = 18'(ANG_QP64);
  localparam logic [17:0] ANG_RP    = 18'(ANG_NUM - ANG_QP64 * 64'(ANG_DIV));
  // partial numerator stays below 2^31, divisor below 2^20, so 51 shift bits are exact
  localparam int          RECIP_SH  = 51;
  localparam logic [31:0] ANG_RECIP =
    32'(udiv64((64'd1 << RECIP_SH) + 64'(ANG_DIV) - 64'd1, 64'(ANG_DIV)));
  localparam int          ANG_QUO_W = 11;

  // atan(2^-i) in q3.28 from the arctangent series on a 2^62 scale
  function automatic atan_tab_t build_atan();
    atan_tab_t   tab;
    longint      acc;
    logic [63:0] t;
    int          sh;
    tab[0] = 32'((64'd843314857 + 64'd2) >> 2);
    for (int i = 1; i < ATAN_COUNT; i++) begin
      acc = 0;
      for (int k = 0; k < 32; k++) begin
        sh = i * (2 * k + 1);
        if (sh <= 62) begin
          t = udiv64(64'h4000_0000_0000_0000 >> sh, 64'(2 * k + 1));
          if ((k % 2) == 1) acc = acc - longint'(t);
          else              acc = acc + longint'(t);
        end
      end
      tab[i] = 32'((acc + (longint'(1) <<< 33)) >>> 34);
    end
    return tab;
  endfunction

endpackage

### rtl/core/mcfm_angle.sv
// gimbal angle scaling and iterative cordic giving sine and cosine
`timescale 1ns / 1ps
module mcfm_angle #(
  parameter int TRIG_FRAC_BITS = 15,
  parameter int CORDIC_STEPS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [12:0]                   ecd_i,
  input  logic [12:0]                   ref_i,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_o,
  output logic                          done_o
);
  import mcfm_pkg::*;

  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam atan_tab_t AtanTab = build_atan();
  localparam logic [AIW-1:0] ROT_LAST = AIW'(CORDIC_STEPS - 1);

  typedef enum logic [2:0] {
    A_IDLE, A_SCALE, A_RECIP, A_SUM, A_FOLD1, A_FOLD2, A_ROT, A_FIN
  } ang_state_e;

  ang_state_e              state_q;
  logic [12:0]             ch_q;
  logic [30:0]             base_q, num_q;
  logic [ANG_QUO_W-1:0]    quo_q;
  logic [30:0]             nb_q;
  logic [AIW-1:0]          cnt_q;
  logic signed [31:0]      z_q;
  logic signed [33:0]      x_q, y_q;
  logic                    neg_q;
  logic signed [TW-1:0]    sin_q, cos_q;
  logic                    done_q;

  logic [12:0]        ch;
  logic [62:0]        recip_p;
  logic signed [33:0] dx, dy, xf, yf;
  logic signed [31:0] z1;

  function automatic logic signed [TW-1:0] to_trig(input logic signed [33:0] q);
    logic signed [33:0] one;
    logic signed [33:0] v;
    one = 34'sd1 <<< TRIG_FRAC_BITS;
    v   = (q + (34'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    if (v > one) v = one;
    if (v < -one) v = -one;
    return TW'(v);
  endfunction

  always_comb begin
    ch      = (ecd_i < ref_i) ? 13'(ECD_SPAN + ecd_i - ref_i) : 13'(ecd_i - ref_i);
    recip_p = 63'(num_q) * 63'(ANG_RECIP);
    dx      = y_q >>> cnt_q;
    dy      = x_q >>> cnt_q;
    z1      = $signed({1'b0, nb_q});
    xf      = neg_q ? -x_q : x_q;
    yf      = neg_q ? -y_q : y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        A_IDLE: begin
          if (start_i) begin
            ch_q    <= ch;
            state_q <= A_SCALE;
          end
        end
        A_SCALE: begin
          base_q  <= 31'(ch_q) * 31'(ANG_QP);
          num_q   <= 31'(ch_q) * 31'(ANG_RP) + 31'(ANG_BIAS);
          state_q <= A_RECIP;
        end
        A_RECIP: begin
          // quotient of the small remainder part by reciprocal multiply
          quo_q   <= ANG_QUO_W'(recip_p >> RECIP_SH);
          state_q <= A_SUM;
        end
        A_SUM: begin
          nb_q    <= base_q + 31'(quo_q);
          state_q <= A_FOLD1;
        end
        A_FOLD1: begin
          z_q     <= (z1 > ANG_PI) ? z1 - ANG_TWO_PI : z1;
          state_q <= A_FOLD2;
        end
        A_FOLD2: begin
          if (z_q > ANG_HALF_PI) begin
            z_q   <= z_q - ANG_PI;
            neg_q <= 1'b1;
          end else if (z_q < -ANG_HALF_PI) begin
            z_q   <= z_q + ANG_PI;
            neg_q <= 1'b1;
          end else begin
            neg_q <= 1'b0;
          end
          x_q     <= GAIN_Q30;
          y_q     <= '0;
          cnt_q   <= '0;
          state_q <= A_ROT;
        end
        A_ROT: begin
          if (!z_q[31]) begin
            x_q <= x_q - dx;
            y_q <= y_q + dy;
            z_q <= z_q - AtanTab[cnt_q];
          end else begin
            x_q <= x_q + dx;
            y_q <= y_q - dy;
            z_q <= z_q + AtanTab[cnt_q];
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == ROT_LAST) state_q <= A_FIN;
        end
        A_FIN: begin
          sin_q   <= to_trig(yf);
          cos_q   <= to_trig(xf);
          done_q  <= 1'b1;
          state_q <= A_IDLE;
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

  assign sin_o  = sin_q;
  assign cos_o  = cos_q;
  assign done_o = done_q;

endmodule

### rtl/core/mcfm_mix.sv
// sequential multiply-accumulate of the rotated stick vector and wheel mixing
`timescale 1ns / 1ps
module mcfm_mix #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [15:0]               sx_i,
  input  logic signed [15:0]               sy_i,
  input  logic signed [TRIG_FRAC_BITS+1:0] sin_i,
  input  logic signed [TRIG_FRAC_BITS+1:0] cos_i,
  input  logic signed [16:0]               rot_i,
  output logic signed [17:0]               w0_o,
  output logic signed [17:0]               w1_o,
  output logic signed [17:0]               w2_o,
  output logic signed [17:0]               w3_o,
  output logic                             done_o
);
  import mcfm_pkg::*;

  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int PW = 16 + TW;
  localparam int AW = PW + 1;
  localparam int WW = AW + 2;

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_FIN} mix_state_e;

  mix_state_e           state_q;
  logic [2:0]           cnt_q;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] avx_q, avy_q;
  logic signed [16:0]   rot_q;
  logic signed [17:0]   w0_q, w1_q, w2_q, w3_q;
  logic                 done_q;

  logic signed [15:0]   mul_a;
  logic signed [TW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [WW-1:0] vx, vy, half;

  function automatic logic signed [17:0] wheel(input logic signed [WW-1:0] w,
                                               input logic signed [WW-1:0] h,
                                               input logic signed [16:0] r);
    logic signed [WW-1:0] s;
    s = (w + h) >>> TRIG_FRAC_BITS;
    return 18'(s) + 18'(r);
  endfunction

  always_comb begin
    mul_a = cnt_q[0] ? sy_i : sx_i;
    case (cnt_q)
      3'd0:    mul_b = cos_i;
      3'd1:    mul_b = sin_i;
      3'd2:    mul_b = sin_i;
      default: mul_b = cos_i;
    endcase
    mul_p = mul_a * mul_b;
    vx    = -WW'(avx_q);
    vy    = WW'(avy_q);
    half  = WW'(1) <<< (TRIG_FRAC_BITS - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        M_IDLE: begin
          if (start_i) begin
            cnt_q   <= '0;
            rot_q   <= rot_i;
            state_q <= M_MUL;
          end
        end
        M_MUL: begin
          // product of step n is accumulated in step n+1
          prod_q <= mul_p;
          case (cnt_q)
            3'd1:    avx_q <= AW'(prod_q);
            3'd2:    avx_q <= avx_q + AW'(prod_q);
            3'd3:    avy_q <= AW'(prod_q);
            3'd4:    avy_q <= avy_q - AW'(prod_q);
            default: ;
          endcase
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 3'd4) state_q <= M_FIN;
        end
        M_FIN: begin
          w0_q    <= wheel(vx - vy, half, rot_q);
          w1_q    <= wheel(vx + vy, half, rot_q);
          w2_q    <= wheel(-vx + vy, half, rot_q);
          w3_q    <= wheel(-vx - vy, half, rot_q);
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign w0_o   = w0_q;
  assign w1_o   = w1_q;
  assign w2_o   = w2_q;
  assign w3_o   = w3_q;
  assign done_o = done_q;

endmodule

### rtl/core/mecanum_chassis_follow_mixer_core.sv
// top level of the mecanum chassis mixer with gimbal follow and spin modes
//
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_stall_o   | mode, switch, keys, stick, yaw encoder
//  out     | output    | out_valid_o / out_stall_i | four wheel targets
//  cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// an item that gives a result reaches out_valid_o after angle scaling by reciprocal
// multiply, two folds, the cordic loop, then four multiplies.
// items giving no result are taken while the core is idle and leave no trace.
// in_stall_o is high from acceptance until the result is in the output register.
// a result held by out_stall_i keeps the next finished result waiting in the core.
// reset restores all registers, the key choice and the front angle.
`timescale 1ns / 1ps
`include "mecanum_chassis_follow_mixer_core_assert.svh"
module mecanum_chassis_follow_mixer_core #(
  parameter int TRIG_FRAC_BITS = mcfm_pkg::TRIG_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS   = mcfm_pkg::CORDIC_STEPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mcfm_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [mcfm_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  mode_i,
  input  logic [1:0]                  rc_switch_i,
  input  logic                        key_follow_i,
  input  logic                        key_spin_i,
  input  logic                        key_alternate_i,
  input  logic signed [15:0]          stick_x_i,
  input  logic signed [15:0]          stick_y_i,
  input  logic [12:0]                 yaw_ecd_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [17:0]          wheel_front_left_o,
  output logic signed [17:0]          wheel_front_right_o,
  output logic signed [17:0]          wheel_rear_right_o,
  output logic signed [17:0]          wheel_rear_left_o
);
  import mcfm_pkg::*;

  localparam int TW = TRIG_FRAC_BITS + 2;

  typedef enum logic [1:0] {ST_IDLE, ST_ANG, ST_MIX, ST_HOLD} core_state_e;

  core_state_e        state_q;
  logic [12:0]        front_def_q, front_alt_q, rot_ref_q, deadband_q;
  logic signed [15:0] spin_speed_q;
  logic [13:0]        limit_q;
  logic [1:0]         key_choice_q;
  logic [12:0]        front_q;
  logic               spin_q;
  logic signed [15:0] sx_q, sy_q;
  logic [12:0]        ecd_q;
  logic               out_valid_q;
  logic signed [17:0] o0_q, o1_q, o2_q, o3_q;

  logic               accept, produce, spin_new, ang_done, mix_done, load_out;
  logic [1:0]         kc_new;
  logic [12:0]        front_new, ang_ref;
  logic signed [13:0] err, err_w, err_abs;
  logic signed [15:0] term, lim;
  logic signed [16:0] rot;
  logic signed [TW-1:0] sin_v, cos_v;
  logic signed [17:0] w0, w1, w2, w3;

  always_comb begin
    accept   = in_valid_i && !in_stall_o;
    produce  = (mode_i == MODE_KEY) || ((mode_i == MODE_RC) && (rc_switch_i != SW_OFF));
    load_out = (state_q == ST_HOLD) && (!out_valid_q || !out_stall_i);

    kc_new = key_choice_q;
    if (key_follow_i && !key_spin_i && !key_alternate_i) kc_new = KEY_FOLLOW;
    if (key_spin_i && !key_follow_i && !key_alternate_i) kc_new = KEY_SPIN;
    if (key_alternate_i && !key_follow_i && !key_spin_i) kc_new = KEY_ALT;

    front_new = front_q;
    if (mode_i == MODE_KEY) begin
      if (kc_new == KEY_FOLLOW)   front_new = front_def_q;
      else if (kc_new == KEY_ALT) front_new = front_alt_q;
    end
    spin_new = (mode_i == MODE_KEY) ? (kc_new == KEY_SPIN) : (rc_switch_i == SW_SPIN);
    ang_ref  = spin_new ? front_new : rot_ref_q;

    // follow term from the stored front angle, wrapped to a half turn
    err = $signed({1'b0, front_q}) - $signed({1'b0, ecd_q});
    if (err > 14'sd4095)       err_w = err - 14'sd8192;
    else if (err < -14'sd4095) err_w = err + 14'sd8192;
    else                       err_w = err;
    err_abs = err_w[13] ? -err_w : err_w;
    lim     = $signed({2'b00, limit_q});
    term    = -(16'(err_w) <<< 1);
    if (term > lim)  term = lim;
    if (term < -lim) term = -lim;
    if (err_abs <= $signed({1'b0, deadband_q})) term = '0;
    rot = spin_q ? 17'(spin_speed_q) : 17'(term);
  end

  mcfm_angle #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
    .CORDIC_STEPS   (CORDIC_STEPS)
  ) u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && produce),
    .ecd_i   (yaw_ecd_i),
    .ref_i   (ang_ref),
    .sin_o   (sin_v),
    .cos_o   (cos_v),
    .done_o  (ang_done)
  );

  mcfm_mix #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ang_done),
    .sx_i    (sx_q),
    .sy_i    (sy_q),
    .sin_i   (sin_v),
    .cos_i   (cos_v),
    .rot_i   (rot),
    .w0_o    (w0),
    .w1_o    (w1),
    .w2_o    (w2),
    .w3_o    (w3),
    .done_o  (mix_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_def_q  <= FRONT_DEF_RST;
      front_alt_q  <= FRONT_ALT_RST;
      rot_ref_q    <= ROT_REF_RST;
      spin_speed_q <= SPIN_RST;
      deadband_q   <= DEADBAND_RST;
      limit_q      <= LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRONT_DEF: front_def_q  <= cfg_data_i[12:0];
        REG_FRONT_ALT: front_alt_q  <= cfg_data_i[12:0];
        REG_ROT_REF:   rot_ref_q    <= cfg_data_i[12:0];
        REG_SPIN:      spin_speed_q <= $signed(cfg_data_i[15:0]);
        REG_DEADBAND:  deadband_q   <= cfg_data_i[12:0];
        REG_LIMIT:     limit_q      <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      key_choice_q <= KEY_FOLLOW;
      front_q      <= FRONT_DEF_RST;
      spin_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (load_out)          out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept && produce) begin
            if (mode_i == MODE_KEY) key_choice_q <= kc_new;
            front_q <= front_new;
            spin_q  <= spin_new;
            sx_q    <= stick_x_i;
            sy_q    <= stick_y_i;
            ecd_q   <= yaw_ecd_i;
            state_q <= ST_ANG;
          end
        end
        ST_ANG: begin
          if (ang_done) state_q <= ST_MIX;
        end
        ST_MIX: begin
          if (mix_done) state_q <= ST_HOLD;
        end
        ST_HOLD: begin
          // wait for the output register to free up
          if (load_out) begin
            o0_q    <= w0;
            o1_q    <= w1;
            o2_q    <= w2;
            o3_q    <= w3;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o          = (state_q != ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign wheel_front_left_o  = o0_q;
  assign wheel_front_right_o = o1_q;
  assign wheel_rear_right_o  = o2_q;
  assign wheel_rear_left_o   = o3_q;

  `MCFM_ASSERT_IMP(a_ang_done_in_ang, ang_done, state_q == ST_ANG)
  `MCFM_ASSERT_IMP(a_mix_done_in_mix, mix_done, state_q == ST_MIX)
  `MCFM_ASSERT_NXT(a_busy_after_accept, accept && produce, in_stall_o && !out_valid_q || in_stall_o)
  `MCFM_ASSERT_NXT(a_hold_loads_out, state_q == ST_HOLD && !out_valid_q, out_valid_q && state_q == ST_IDLE)

endmodule

### sim/testbench.sv
// self-checking testbench of the mecanum chassis mixer core
`timescale 1ns / 1ps
module testbench;
  import mcfm_pkg::*;

  typedef struct {
    logic [1:0]         mode;
    logic [1:0]         sw;
    logic               kf, ks, ka;
    logic signed [15:0] sx, sy;
    logic [12:0]        ecd;
  } tick_t;

  typedef struct {
    logic signed [17:0] fl, fr, rr, rl;
  } wheels_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] mode_i = '0, rc_switch_i = '0;
  logic key_follow_i = 1'b0, key_spin_i = 1'b0, key_alternate_i = 1'b0;
  logic signed [15:0] stick_x_i = '0, stick_y_i = '0;
  logic [12:0] yaw_ecd_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [17:0] wheel_front_left_o, wheel_front_right_o;
  logic signed [17:0] wheel_rear_right_o, wheel_rear_left_o;

  mecanum_chassis_follow_mixer_core i_dut (.*);

  always #10 clk_i = ~clk_i;

  // predictor copy of registers and state
  logic [12:0] p_front_def, p_front_alt, p_rot_ref, p_deadband, p_front;
  logic signed [15:0] p_spin;
  logic [13:0] p_limit;
  logic [1:0] p_choice;
  longint atan_q28 [ATAN_COUNT];

  tick_t   tick_q[$];
  wheels_t wheels_q[$];
  int      errors = 0;

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint trig_round(longint q30);
    longint v;
    v = sra(q30 + (longint'(1) << (29 - 15)), 15);
    if (v > 32768) v = 32768;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic gimbal_sin_cos(input logic [12:0] ecd, input logic [12:0] ref_a,
                                output longint s, output longint c);
    longint ch, z, x, y, dx, dy;
    bit neg;
    neg = 0;
    ch = (ecd < ref_a) ? 8191 + longint'(ecd) - longint'(ref_a)
                       : longint'(ecd) - longint'(ref_a);
    z = (ch * 628 * (longint'(1) << 28) + 409550) / 819100;
    x = 652032874;
    y = 0;
    if (z > 843314857) z -= 2 * 64'sd843314857;
    if (z > 421657428) begin
      z -= 843314857; neg = 1;
    end else if (z < -421657428) begin
      z += 843314857; neg = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = sra(y, i);
      dy = sra(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q28[i];
      end else begin
        x += dx; y -= dy; z += atan_q28[i];
      end
    end
    if (neg) begin
      x = -x; y = -y;
    end
    s = trig_round(y);
    c = trig_round(x);
  endtask

  task automatic predict_wheels(input tick_t t);
    bit spin;
    longint s, c, vx, vy, rot, e, w[4];
    wheels_t r;
    if (t.mode == MODE_RC) begin
      if (t.sw == SW_OFF) return;
      spin = (t.sw == SW_SPIN);
    end else if (t.mode == MODE_KEY) begin
      if (t.kf && !t.ks && !t.ka) p_choice = KEY_FOLLOW;
      if (t.ks && !t.kf && !t.ka) p_choice = KEY_SPIN;
      if (t.ka && !t.kf && !t.ks) p_choice = KEY_ALT;
      if (p_choice == KEY_FOLLOW) p_front = p_front_def;
      else if (p_choice == KEY_ALT) p_front = p_front_alt;
      spin = (p_choice == KEY_SPIN);
    end else return;
    gimbal_sin_cos(t.ecd, spin ? p_front : p_rot_ref, s, c);
    if (spin) rot = p_spin;
    else begin
      e = longint'(p_front) - longint'(t.ecd);
      if (e > 4095) e -= 8192;
      else if (e < -4095) e += 8192;
      if ((e < 0 ? -e : e) <= longint'(p_deadband)) rot = 0;
      else begin
        rot = -2 * e;
        if (rot > longint'(p_limit)) rot = p_limit;
        if (rot < -longint'(p_limit)) rot = -longint'(p_limit);
      end
    end
    vx = -(longint'(t.sx) * c + longint'(t.sy) * s);
    vy = -(-longint'(t.sx) * s + longint'(t.sy) * c);
    w[0] = vx - vy; w[1] = vx + vy; w[2] = -vx + vy; w[3] = -vx - vy;
    for (int j = 0; j < 4; j++) w[j] = sra(w[j] + 16384, 15) + rot;
    r.fl = w[0][17:0]; r.fr = w[1][17:0]; r.rr = w[2][17:0]; r.rl = w[3][17:0];
    wheels_q.push_back(r);
  endtask

  task automatic report(input string what, input longint got, input longint exp_v);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
    errors++;
  endtask

  // driver: bursts and gaps, the queue head is the item on the bus
  int gap = 0, burst = 0;
  always @(posedge clk_i) begin
    tick_t t;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_wheels(tick_q.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_valid_i <= 1'b0;
        end else if (tick_q.size() > 0) begin
          t = tick_q[0];
          in_valid_i <= 1'b1;
          mode_i <= t.mode; rc_switch_i <= t.sw;
          key_follow_i <= t.kf; key_spin_i <= t.ks; key_alternate_i <= t.ka;
          stick_x_i <= t.sx; stick_y_i <= t.sy; yaw_ecd_i <= t.ecd;
          if (burst > 0) burst <= burst - 1;
          else begin
            burst <= $urandom_range(0, 12);
            gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else in_valid_i <= 1'b0;
      end
    end
  end

  // monitor with its own stall pattern
  int stall_phase = 0;
  always @(posedge clk_i) begin
    wheels_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (wheels_q.size() == 0) begin
          report("unexpected transfer", 1, 0);
        end else begin
          e = wheels_q.pop_front();
          if (wheel_front_left_o !== e.fl) report("front_left", wheel_front_left_o, e.fl);
          if (wheel_front_right_o !== e.fr) report("front_right", wheel_front_right_o, e.fr);
          if (wheel_rear_right_o !== e.rr) report("rear_right", wheel_rear_right_o, e.rr);
          if (wheel_rear_left_o !== e.rl) report("rear_left", wheel_rear_left_o, e.rl);
        end
      end
      stall_phase <= (stall_phase + 1) % 300;
      if (stall_phase < 100) out_stall_i <= 1'b0;
      else if (stall_phase < 200) out_stall_i <= ($urandom_range(0, 3) == 0);
      else out_stall_i <= ($urandom_range(0, 1) == 0) ? 1'b1 : ($urandom_range(0, 5) == 0);
    end
  end

  function automatic tick_t make_tick(logic [1:0] m, logic [1:0] s, logic kf, logic ks,
                                      logic ka, logic signed [15:0] x,
                                      logic signed [15:0] y, logic [12:0] ecd);
    tick_t t;
    t.mode = m; t.sw = s; t.kf = kf; t.ks = ks; t.ka = ka; t.sx = x; t.sy = y; t.ecd = ecd;
    return t;
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int r;
    r = $urandom_range(0, 99);
    t.mode = (r < 45) ? MODE_RC : (r < 92) ? MODE_KEY : 2'($urandom_range(0, 3));
    t.sw = ($urandom_range(0, 9) == 0) ? SW_OFF : 2'($urandom_range(1, 3));
    r = $urandom_range(0, 9);
    t.kf = (r < 3); t.ks = (r >= 3 && r < 6); t.ka = (r >= 6 && r < 8);
    if (r >= 8) begin
      t.kf = 1'($urandom); t.ks = 1'($urandom); t.ka = 1'($urandom);
    end
    t.sx = 16'($urandom); t.sy = 16'($urandom);
    t.ecd = 13'($urandom_range(0, 8191));
    if ($urandom_range(0, 4) == 0) t.ecd = p_front + 13'($urandom_range(0, 400)) - 13'd200;
    return t;
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_FRONT_DEF: p_front_def = v[12:0];
      REG_FRONT_ALT: p_front_alt = v[12:0];
      REG_ROT_REF:   p_rot_ref = v[12:0];
      REG_SPIN:      p_spin = v;
      REG_DEADBAND:  p_deadband = v[12:0];
      REG_LIMIT:     p_limit = v[13:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (tick_q.size() == 0 && !in_valid_i && wheels_q.size() == 0);
    repeat (120) @(posedge clk_i);
  endtask

  initial begin
    atan_tab_t tab;
    tab = build_atan();
    for (int i = 0; i < ATAN_COUNT; i++) atan_q28[i] = tab[i];
    p_front_def = FRONT_DEF_RST; p_front_alt = FRONT_ALT_RST; p_rot_ref = ROT_REF_RST;
    p_spin = SPIN_RST; p_deadband = DEADBAND_RST; p_limit = LIMIT_RST;
    p_choice = KEY_FOLLOW; p_front = FRONT_DEF_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: sources, switch, keys, stick and encoder extremes
    tick_q.push_back(make_tick(2'd0, 2'd1, 1'b1, 1'b0, 1'b0, 16'sd100, 16'sd100, 13'd0));
    tick_q.push_back(make_tick(2'd3, 2'd2, 1'b0, 1'b1, 1'b0, 16'sd100, 16'sd100, 13'd0));
    tick_q.push_back(make_tick(MODE_RC, SW_OFF, 1'b0, 1'b0, 1'b0, 16'sd5, 16'sd5, 13'd10));
    tick_q.push_back(make_tick(MODE_RC, 2'd1, 1'b1, 1'b1, 1'b1, 16'sh7fff, 16'sh7fff,
                               13'd8191));
    tick_q.push_back(make_tick(MODE_RC, 2'd3, 1'b0, 1'b0, 1'b0, 16'sh8000, 16'sh8000,
                               13'd0));
    tick_q.push_back(make_tick(MODE_RC, SW_SPIN, 1'b0, 1'b0, 1'b0, 16'sh8000, 16'sh7fff,
                               13'd1335));
    tick_q.push_back(make_tick(MODE_KEY, SW_OFF, 1'b0, 1'b1, 1'b0, 16'sh7fff, 16'sh8000,
                               13'd4000));
    tick_q.push_back(make_tick(MODE_KEY, SW_OFF, 1'b1, 1'b1, 1'b0, 16'sd1000, -16'sd1000,
                               13'd6000));
    tick_q.push_back(make_tick(MODE_KEY, SW_OFF, 1'b0, 1'b0, 1'b1, -16'sd3000, 16'sd200,
                               13'd2316));
    tick_q.push_back(make_tick(MODE_KEY, SW_OFF, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 13'd2472));
    tick_q.push_back(make_tick(MODE_KEY, SW_OFF, 1'b1, 1'b0, 1'b0, 16'sd0, 16'sd0, 13'd1491));
    tick_q.push_back(make_tick(MODE_KEY, SW_OFF, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 13'd1492));
    tick_q.push_back(make_tick(MODE_KEY, SW_OFF, 1'b0, 1'b0, 1'b0, 16'sd7, -16'sd7, 13'd5431));
    tick_q.push_back(make_tick(MODE_KEY, SW_OFF, 1'b0, 1'b0, 1'b0, 16'sd7, -16'sd7, 13'd5430));
    tick_q.push_back(make_tick(MODE_KEY, SW_OFF, 1'b1, 1'b0, 1'b1, 16'sd12345, -16'sd222,
                               13'd8191));
    tick_q.push_back(make_tick(MODE_RC, 2'd1, 1'b0, 1'b0, 1'b0, 16'sh7fff, 16'sd0, 13'd1335));
    drain();

    // phases over register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ;
        1: begin
          write_reg(REG_FRONT_DEF, 16'd0); write_reg(REG_FRONT_ALT, 16'd8191);
          write_reg(REG_ROT_REF, 16'd0); write_reg(REG_SPIN, 16'h8000);
          write_reg(REG_DEADBAND, 16'd0); write_reg(REG_LIMIT, 16'd16383);
        end
        2: begin
          write_reg(REG_FRONT_DEF, 16'd8191); write_reg(REG_FRONT_ALT, 16'd0);
          write_reg(REG_ROT_REF, 16'd8191); write_reg(REG_SPIN, 16'h7fff);
          write_reg(REG_DEADBAND, 16'd4096); write_reg(REG_LIMIT, 16'd0);
        end
        default: begin
          write_reg(REG_FRONT_DEF, 16'($urandom_range(0, 8191)));
          write_reg(REG_FRONT_ALT, 16'($urandom_range(0, 8191)));
          write_reg(REG_ROT_REF, 16'($urandom_range(0, 8191)));
          write_reg(REG_SPIN, 16'($urandom));
          write_reg(REG_DEADBAND, 16'($urandom_range(0, 4096)));
          write_reg(REG_LIMIT, 16'($urandom_range(0, 16383)));
        end
      endcase
      for (int n = 0; n < 115; n++) tick_q.push_back(rand_tick());
      drain();
    end
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #(64'd150_000_000);
    $display("Verification failed");
    $finish;
  end
endmodule

### mecanum_chassis_follow_mixer_core.f
+incdir+rtl/core
rtl/core/mcfm_pkg.sv
rtl/core/mcfm_angle.sv
rtl/core/mcfm_mix.sv
rtl/core/mecanum_chassis_follow_mixer_core.sv
sim/testbench.sv
